/* sv/tuc_pkg.sv */
`default_nettype none

package tuc_pkg;

  // Sensor geometry
  localparam int SENSOR_COLS = 32;
  localparam int SENSOR_ROWS = 24;
  localparam int STORE_DEPTH = SENSOR_COLS * SENSOR_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Upscaled coordinate limits (last column and the rows past the last sample are rejected)
  localparam int FETCH_COL_LIM = 3 * (SENSOR_COLS - 1);
  localparam int FETCH_ROW_LIM = 3 * SENSOR_ROWS - 2;

  // Field widths
  localparam int COORD_W  = 7;
  localparam int SAMPLE_W = 16;
  localparam int TEMP_W   = 10;
  localparam int IDX_W    = 8;
  localparam int COLOR_W  = 16;
  localparam int CFG_IDX_W = 1;

  // Divide by 3 on a coordinate: (c * 43) >> 7 is exact for c < 128
  localparam int DIV3_MUL   = 43;
  localparam int DIV3_SHIFT = 7;
  localparam int DIV3_W     = COORD_W + 6;
  localparam int SUB_W      = DIV3_W - DIV3_SHIFT;

  // Interpolation widths
  localparam int H_W   = SAMPLE_W + 2;
  localparam int NUM_W = SAMPLE_W + 4;

  // Floor divide by 9: bias to non-negative, then multiply by ceil(2^24/9)
  localparam int NUM_BIAS   = 9 * 32768;
  localparam int Q_BIAS     = 32768;
  localparam int DIV9_MUL   = 1864136;
  localparam int DIV9_SHIFT = 24;
  localparam int DIV9_MUL_W = 21;
  localparam int PROD_W     = NUM_W + DIV9_MUL_W;
  localparam int Q_W        = PROD_W - DIV9_SHIFT;

  // Palette index divider: numerator (t-min)*255, 2 quotient bits per step
  localparam int NUMER_W    = 18;
  localparam int RADIX_BITS = 2;
  localparam int DIV_STEPS  = IDX_W / RADIX_BITS;
  localparam int DIV_K_W    = $clog2(DIV_STEPS);
  localparam int REM_W      = NUMER_W + 1;

  // Opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 1'b1;

  localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = 10'sd24;
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 10'sd35;

  // Neighbor select: bit 1 = lower row, bit 0 = right column
  localparam logic [1:0] NB_00 = 2'd0;
  localparam logic [1:0] NB_01 = 2'd1;
  localparam logic [1:0] NB_10 = 2'd2;
  localparam logic [1:0] NB_11 = 2'd3;

  typedef struct packed {
    logic               capture;
    logic               mem_we;
    logic               rd_en;
    logic [1:0]         rd_sel;
    logic               smp_we;
    logic [1:0]         smp_sel;
    logic               horz;
    logic               vert;
    logic               quot;
    logic               floor_en;
    logic               clamp;
    logic               div_step;
    logic [DIV_K_W-1:0] div_k;
    logic               finish_fetch;
    logic               finish_zero;
    logic               set_err;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic load_err;
    logic fetch_err;
    logic ky_zero;
  } status_t;

  localparam logic [COLOR_W-1:0] PALETTE [256] = '{
    16'h480F, 16'h400F, 16'h400F, 16'h400F, 16'h4010, 16'h3810, 16'h3810, 16'h3810,
    16'h3810, 16'h3010, 16'h3010, 16'h3010, 16'h2810, 16'h2810, 16'h2810, 16'h2810,
    16'h2010, 16'h2010, 16'h2010, 16'h1810, 16'h1810, 16'h1811, 16'h1811, 16'h1011,
    16'h1011, 16'h1011, 16'h0811, 16'h0811, 16'h0811, 16'h0011, 16'h0011, 16'h0011,
    16'h0011, 16'h0011, 16'h0031, 16'h0031, 16'h0051, 16'h0072, 16'h0072, 16'h0092,
    16'h00B2, 16'h00B2, 16'h00D2, 16'h00F2, 16'h00F2, 16'h0112, 16'h0132, 16'h0152,
    16'h0152, 16'h0172, 16'h0192, 16'h0192, 16'h01B2, 16'h01D2, 16'h01F3, 16'h01F3,
    16'h0213, 16'h0233, 16'h0253, 16'h0253, 16'h0273, 16'h0293, 16'h02B3, 16'h02D3,
    16'h02D3, 16'h02F3, 16'h0313, 16'h0333, 16'h0333, 16'h0353, 16'h0373, 16'h0394,
    16'h03B4, 16'h03D4, 16'h03D4, 16'h03F4, 16'h0414, 16'h0434, 16'h0454, 16'h0474,
    16'h0474, 16'h0494, 16'h04B4, 16'h04D4, 16'h04F4, 16'h0514, 16'h0534, 16'h0534,
    16'h0554, 16'h0554, 16'h0574, 16'h0574, 16'h0573, 16'h0573, 16'h0573, 16'h0572,
    16'h0572, 16'h0572, 16'h0571, 16'h0591, 16'h0591, 16'h0590, 16'h0590, 16'h058F,
    16'h058F, 16'h058F, 16'h058E, 16'h05AE, 16'h05AE, 16'h05AD, 16'h05AD, 16'h05AD,
    16'h05AC, 16'h05AC, 16'h05AB, 16'h05CB, 16'h05CB, 16'h05CA, 16'h05CA, 16'h05CA,
    16'h05C9, 16'h05C9, 16'h05C8, 16'h05E8, 16'h05E8, 16'h05E7, 16'h05E7, 16'h05E6,
    16'h05E6, 16'h05E6, 16'h05E5, 16'h05E5, 16'h0604, 16'h0604, 16'h0604, 16'h0603,
    16'h0603, 16'h0602, 16'h0602, 16'h0601, 16'h0621, 16'h0621, 16'h0620, 16'h0620,
    16'h0620, 16'h0620, 16'h0E20, 16'h0E20, 16'h0E40, 16'h1640, 16'h1640, 16'h1E40,
    16'h1E40, 16'h2640, 16'h2640, 16'h2E40, 16'h2E60, 16'h3660, 16'h3660, 16'h3E60,
    16'h3E60, 16'h3E60, 16'h4660, 16'h4660, 16'h4E60, 16'h4E80, 16'h5680, 16'h5680,
    16'h5E80, 16'h5E80, 16'h6680, 16'h6680, 16'h6E80, 16'h6EA0, 16'h76A0, 16'h76A0,
    16'h7EA0, 16'h7EA0, 16'h86A0, 16'h86A0, 16'h8EA0, 16'h8EC0, 16'h96C0, 16'h96C0,
    16'h9EC0, 16'h9EC0, 16'hA6C0, 16'hAEC0, 16'hAEC0, 16'hB6E0, 16'hB6E0, 16'hBEE0,
    16'hBEE0, 16'hC6E0, 16'hC6E0, 16'hCEE0, 16'hCEE0, 16'hD6E0, 16'hD700, 16'hDF00,
    16'hDEE0, 16'hDEC0, 16'hDEA0, 16'hDE80, 16'hDE80, 16'hE660, 16'hE640, 16'hE620,
    16'hE600, 16'hE5E0, 16'hE5C0, 16'hE5A0, 16'hE580, 16'hE560, 16'hE540, 16'hE520,
    16'hE500, 16'hE4E0, 16'hE4C0, 16'hE4A0, 16'hE480, 16'hE460, 16'hEC40, 16'hEC20,
    16'hEC00, 16'hEBE0, 16'hEBC0, 16'hEBA0, 16'hEB80, 16'hEB60, 16'hEB40, 16'hEB20,
    16'hEB00, 16'hEAE0, 16'hEAC0, 16'hEAA0, 16'hEA80, 16'hEA60, 16'hEA40, 16'hF220,
    16'hF200, 16'hF1E0, 16'hF1C0, 16'hF1A0, 16'hF180, 16'hF160, 16'hF140, 16'hF100,
    16'hF0E0, 16'hF0C0, 16'hF0A0, 16'hF080, 16'hF060, 16'hF040, 16'hF020, 16'hF800
  };

endpackage

`default_nettype wire

/* sv/thermal_upscale_colorize_core.sv */
// Thermal frame store with 3x bilinear upscale and RGB565 false color.
//
// Command channel: an item is taken on a rising edge with start high and
// busy low. opcode 0 loads one sample (col, row, temperature) into the
// frame at the mirrored column; opcode 1 fetches upscaled pixel (col, row).
// Result channel: done_o strobes for one cycle with value_o, color_index_o,
// color_o and error_o. The receiver cannot stall; each beat must be taken
// in that cycle. The result registers hold until the next beat.
// A load or a rejected item finishes straight from the decode state. A
// fetch reads its four neighbors (only the upper two on rows that fall on
// a sample row), then runs the horizontal and vertical weighting, the floor
// divide by 9 (multiply, then unbias), the clamp, the 2-bit-per-cycle palette
// index divider and the palette lookup. busy falls as the strobe rises, so
// the next item may start in the strobe cycle; no new item is taken while
// one is in flight. The frame memory serves the reads through one read port.
// Config: cfg_we_i writes min_temp (index 0) or max_temp (index 1) at once;
// write only while idle. Reset sets the limits to 24 and 35 and the
// sequencer to idle; the frame memory is not cleared (unloaded entries
// read as whatever the memory holds).
`default_nettype none

module thermal_upscale_colorize_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode_i,
  input  logic [tuc_pkg::COORD_W-1:0]         col_i,
  input  logic [tuc_pkg::COORD_W-1:0]         row_i,
  input  logic signed [tuc_pkg::SAMPLE_W-1:0] temperature_i,
  input  logic                                cfg_we_i,
  input  logic [tuc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tuc_pkg::TEMP_W-1:0]          cfg_data_i,
  output logic                                done_o,
  output logic signed [tuc_pkg::SAMPLE_W-1:0] value_o,
  output logic [tuc_pkg::IDX_W-1:0]           color_index_o,
  output logic [tuc_pkg::COLOR_W-1:0]         color_o,
  output logic                                error_o
);

  import tuc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: decode, memory read order, pipeline step enables
  tuc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // frame memory, interpolation, clamp, index divider, palette
  tuc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .opcode_i      (opcode_i),
    .col_i         (col_i),
    .row_i         (row_i),
    .temperature_i (temperature_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .value_o       (value_o),
    .color_index_o (color_index_o),
    .color_o       (color_o),
    .error_o       (error_o)
  );

endmodule

`default_nettype wire

/* sv/tuc_ram.sv */
`default_nettype none

module tuc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/tuc_ctrl.sv */
`default_nettype none

module tuc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             done_o,
  input  tuc_pkg::status_t status_i,
  output tuc_pkg::cmd_t    cmd_o
);

  import tuc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RD1    = 4'd2;
  localparam logic [3:0] S_RD2    = 4'd3;
  localparam logic [3:0] S_RD3    = 4'd4;
  localparam logic [3:0] S_RD4    = 4'd5;
  localparam logic [3:0] S_HORZ   = 4'd6;
  localparam logic [3:0] S_VERT   = 4'd7;
  localparam logic [3:0] S_QUOT   = 4'd8;
  localparam logic [3:0] S_FLOOR  = 4'd9;
  localparam logic [3:0] S_CLAMP  = 4'd10;
  localparam logic [3:0] S_DIV    = 4'd11;
  localparam logic [3:0] S_COLOR  = 4'd12;

  logic [3:0]         state_q, state_d;
  logic [DIV_K_W-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.is_load) begin
          cmd_o.mem_we      = !status_i.load_err;
          cmd_o.finish_zero = 1'b1;
          cmd_o.set_err     = status_i.load_err;
          done_d            = 1'b1;
          state_d           = S_IDLE;
        end else if (status_i.fetch_err) begin
          cmd_o.finish_zero = 1'b1;
          cmd_o.set_err     = 1'b1;
          done_d            = 1'b1;
          state_d           = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = NB_00;
          state_d      = S_RD1;
        end
      end
      S_RD1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = NB_01;
        cmd_o.smp_we  = 1'b1;
        cmd_o.smp_sel = NB_00;
        state_d       = S_RD2;
      end
      S_RD2: begin
        cmd_o.smp_we  = 1'b1;
        cmd_o.smp_sel = NB_01;
        // lower row carries no weight on rows that hit a sample row exactly
        if (status_i.ky_zero) begin
          state_d = S_HORZ;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = NB_10;
          state_d      = S_RD3;
        end
      end
      S_RD3: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = NB_11;
        cmd_o.smp_we  = 1'b1;
        cmd_o.smp_sel = NB_10;
        state_d       = S_RD4;
      end
      S_RD4: begin
        cmd_o.smp_we  = 1'b1;
        cmd_o.smp_sel = NB_11;
        state_d       = S_HORZ;
      end
      S_HORZ: begin
        cmd_o.horz = 1'b1;
        state_d    = S_VERT;
      end
      S_VERT: begin
        cmd_o.vert = 1'b1;
        state_d    = S_QUOT;
      end
      S_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d    = S_FLOOR;
      end
      S_FLOOR: begin
        cmd_o.floor_en = 1'b1;
        state_d        = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        cnt_d       = DIV_K_W'(DIV_STEPS - 1);
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_k    = cnt_q;
        if (cnt_q == '0) begin
          state_d = S_COLOR;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_COLOR: begin
        cmd_o.finish_fetch = 1'b1;
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

/* sv/tuc_datapath.sv */
`default_nettype none

module tuc_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  tuc_pkg::cmd_t                          cmd_i,
  output tuc_pkg::status_t                       status_o,
  input  logic                                   opcode_i,
  input  logic [tuc_pkg::COORD_W-1:0]            col_i,
  input  logic [tuc_pkg::COORD_W-1:0]            row_i,
  input  logic signed [tuc_pkg::SAMPLE_W-1:0]    temperature_i,
  input  logic                                   cfg_we_i,
  input  logic [tuc_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [tuc_pkg::TEMP_W-1:0]             cfg_data_i,
  output logic signed [tuc_pkg::SAMPLE_W-1:0]    value_o,
  output logic [tuc_pkg::IDX_W-1:0]              color_index_o,
  output logic [tuc_pkg::COLOR_W-1:0]            color_o,
  output logic                                   error_o
);

  import tuc_pkg::*;

  // config
  logic signed [TEMP_W-1:0] min_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_TEMP_RST;
      max_q <= MAX_TEMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_TEMP: min_q <= $signed(cfg_data_i);
        CFG_MAX_TEMP: max_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // captured item
  logic                       op_q;
  logic [COORD_W-1:0]         col_q, row_q;
  logic signed [SAMPLE_W-1:0] temp_q;

  // coordinate split into sample index and phase
  logic [DIV3_W-1:0] col_m, row_m;
  logic [SUB_W-1:0]  xs, ys;
  logic [COORD_W:0]  kx_w, ky_w;
  logic [1:0]        kx, ky;

  assign col_m = DIV3_W'(col_q) * DIV3_W'(DIV3_MUL);
  assign row_m = DIV3_W'(row_q) * DIV3_W'(DIV3_MUL);
  assign xs    = col_m[DIV3_W-1:DIV3_SHIFT];
  assign ys    = row_m[DIV3_W-1:DIV3_SHIFT];
  assign kx_w  = (COORD_W+1)'(col_q) - (COORD_W+1)'(xs) - (COORD_W+1)'({xs, 1'b0});
  assign ky_w  = (COORD_W+1)'(row_q) - (COORD_W+1)'(ys) - (COORD_W+1)'({ys, 1'b0});
  assign kx    = kx_w[1:0];
  assign ky    = ky_w[1:0];

  assign status_o.is_load   = (op_q == OP_LOAD);
  assign status_o.load_err  = (int'(col_q) >= SENSOR_COLS) || (int'(row_q) >= SENSOR_ROWS);
  assign status_o.fetch_err = (int'(col_q) >= FETCH_COL_LIM) || (int'(row_q) >= FETCH_ROW_LIM);
  assign status_o.ky_zero   = (ky == 2'd0);

  // frame store, column mirrored on load
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [SAMPLE_W-1:0] rdata;

  assign waddr = ADDR_W'(int'(row_q) * SENSOR_COLS + (SENSOR_COLS - 1) - int'(col_q));
  assign raddr = ADDR_W'((int'(ys) + int'(cmd_i.rd_sel[1])) * SENSOR_COLS
                         + int'(xs) + int'(cmd_i.rd_sel[0]));

  tuc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .waddr_i (waddr),
    .wdata_i (temp_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // interpolation pipeline
  logic signed [SAMPLE_W-1:0] p_q [4];
  logic signed [H_W-1:0]      h0_q, h1_q, h0_d, h1_d;
  logic signed [NUM_W-1:0]    num_q, num_d;
  logic [PROD_W-1:0]          prod_q, prod_d;
  logic signed [Q_W-1:0]      q_q, q_d;
  logic signed [2:0]          wx0, wx1, wy0, wy1;
  logic [NUM_W-1:0]           biased;

  assign wx0 = 3'(2'd2 - kx);
  assign wx1 = 3'(kx + 2'd1);
  assign wy0 = 3'(2'd3 - ky);
  assign wy1 = {1'b0, ky};

  assign h0_d = H_W'(p_q[0]) * H_W'(wx0) + H_W'(p_q[1]) * H_W'(wx1);
  assign h1_d = H_W'(p_q[2]) * H_W'(wx0) + H_W'(p_q[3]) * H_W'(wx1);
  assign num_d = NUM_W'(h0_q) * NUM_W'(wy0) + NUM_W'(h1_q) * NUM_W'(wy1);
  assign biased = $unsigned(num_q) + NUM_W'(NUM_BIAS);
  assign prod_d = PROD_W'(biased) * PROD_W'(DIV9_MUL);
  assign q_d    = $signed(prod_q[PROD_W-1:DIV9_SHIFT]) - Q_W'(Q_BIAS);

  // clamp, whole degrees, index numerator and divisor
  logic signed [Q_W-1:0]    hi64, lo64, tq;
  logic signed [TEMP_W-1:0] t;
  logic signed [TEMP_W:0]   diff, span;
  logic [NUMER_W-1:0]       numer_d;
  logic [TEMP_W-1:0]        dv_d;

  assign hi64 = Q_W'(max_q) <<< 6;
  assign lo64 = Q_W'(min_q) <<< 6;

  always_comb begin
    tq = q_q >>> 6;
    // toward zero for negative values with a fraction
    if (q_q[Q_W-1] && (q_q[5:0] != 6'd0)) begin
      tq = tq + 1'b1;
    end
    if (q_q >= hi64) begin
      t = max_q;
    end else if (q_q <= lo64) begin
      t = min_q;
    end else begin
      t = tq[TEMP_W-1:0];
    end
    diff = (TEMP_W+1)'(t) - (TEMP_W+1)'(min_q);
    span = (TEMP_W+1)'(max_q) - (TEMP_W+1)'(min_q);
    if (span > 0) begin
      numer_d = (NUMER_W'(diff) << 8) - NUMER_W'(diff);
      dv_d    = span[TEMP_W-1:0];
    end else if ((span < 0) && (t == max_q)) begin
      // crossed limits pinned at max: top of the palette
      numer_d = NUMER_W'(255);
      dv_d    = TEMP_W'(1);
    end else begin
      numer_d = '0;
      dv_d    = TEMP_W'(1);
    end
  end

  // restoring divider, RADIX_BITS quotient bits per step
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [IDX_W-1:0]  quo_q, quo_d;
  logic [TEMP_W-1:0] dv_q;
  logic [REM_W-1:0]  trial;
  logic [$clog2(IDX_W)-1:0] bit_idx;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    trial   = '0;
    bit_idx = '0;
    for (int i = RADIX_BITS - 1; i >= 0; i--) begin
      bit_idx = $clog2(IDX_W)'(int'(cmd_i.div_k) * RADIX_BITS + i);
      trial   = REM_W'(dv_q) << bit_idx;
      if (rem_d >= trial) begin
        rem_d          = rem_d - trial;
        quo_d[bit_idx] = 1'b1;
      end
    end
  end

  // result registers
  logic signed [SAMPLE_W-1:0] value_q;
  logic [IDX_W-1:0]           idx_q;
  logic [COLOR_W-1:0]         color_q;
  logic                       err_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      col_q  <= col_i;
      row_q  <= row_i;
      temp_q <= temperature_i;
      for (int i = 0; i < 4; i++) begin
        p_q[i] <= '0;
      end
    end
    if (cmd_i.smp_we) begin
      p_q[cmd_i.smp_sel] <= $signed(rdata);
    end
    if (cmd_i.horz) begin
      h0_q <= h0_d;
      h1_q <= h1_d;
    end
    if (cmd_i.vert) begin
      num_q <= num_d;
    end
    if (cmd_i.quot) begin
      prod_q <= prod_d;
    end
    if (cmd_i.floor_en) begin
      q_q <= q_d;
    end
    if (cmd_i.clamp) begin
      rem_q <= REM_W'(numer_d);
      quo_q <= '0;
      dv_q  <= dv_d;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.finish_fetch) begin
      value_q <= q_q[SAMPLE_W-1:0];
      idx_q   <= quo_q;
      color_q <= PALETTE[quo_q];
      err_q   <= 1'b0;
    end
    if (cmd_i.finish_zero) begin
      value_q <= '0;
      idx_q   <= '0;
      color_q <= '0;
      err_q   <= cmd_i.set_err;
    end
  end

  assign value_o       = value_q;
  assign color_index_o = idx_q;
  assign color_o       = color_q;
  assign error_o       = err_q;

endmodule

`default_nettype wire

/* sv/tuc_checker.sv */
`default_nettype none

module tuc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_i,
  input logic        done_i,
  input logic [15:0] value_i,
  input logic [7:0]  color_index_i,
  input logic [15:0] color_i,
  input logic        error_i
);

  // a result beat only ever shows once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |=> busy_i)
    else $error("accepted item did not raise busy");

  // every item ends in exactly one beat
  a_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> done_i)
    else $error("item finished without a result beat");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("result beat repeated");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && error_i) |-> (value_i == 16'd0 && color_index_i == 8'd0 && color_i == 16'd0))
    else $error("rejected item returned nonzero payload");

endmodule

bind thermal_upscale_colorize_core tuc_checker u_tuc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start),
  .busy_i        (busy),
  .done_i        (done_o),
  .value_i       (value_o),
  .color_index_i (color_index_o),
  .color_i       (color_o),
  .error_i       (error_o)
);

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;
  import tuc_pkg::*;

  // Longest stretch with neither a command nor a result beat. This is far
  // beyond the longest fetch plus the longest sender gap in a healthy run.
  localparam int STALL_LIMIT = 500;
  localparam int PHASE_ITEMS = 128;
  localparam int NUM_PHASES  = 8;
  localparam int FETCH_COLS  = 3 * (SENSOR_COLS - 1);
  localparam int FETCH_ROWS  = 3 * SENSOR_ROWS - 2;

  // RGB565 false-color table, entry 0 cold (purple) through 255 hot (red)
  localparam logic [COLOR_W-1:0] RGB565_LUT [256] = '{
    16'h480F, 16'h400F, 16'h400F, 16'h400F, 16'h4010, 16'h3810, 16'h3810, 16'h3810,
    16'h3810, 16'h3010, 16'h3010, 16'h3010, 16'h2810, 16'h2810, 16'h2810, 16'h2810,
    16'h2010, 16'h2010, 16'h2010, 16'h1810, 16'h1810, 16'h1811, 16'h1811, 16'h1011,
    16'h1011, 16'h1011, 16'h0811, 16'h0811, 16'h0811, 16'h0011, 16'h0011, 16'h0011,
    16'h0011, 16'h0011, 16'h0031, 16'h0031, 16'h0051, 16'h0072, 16'h0072, 16'h0092,
    16'h00B2, 16'h00B2, 16'h00D2, 16'h00F2, 16'h00F2, 16'h0112, 16'h0132, 16'h0152,
    16'h0152, 16'h0172, 16'h0192, 16'h0192, 16'h01B2, 16'h01D2, 16'h01F3, 16'h01F3,
    16'h0213, 16'h0233, 16'h0253, 16'h0253, 16'h0273, 16'h0293, 16'h02B3, 16'h02D3,
    16'h02D3, 16'h02F3, 16'h0313, 16'h0333, 16'h0333, 16'h0353, 16'h0373, 16'h0394,
    16'h03B4, 16'h03D4, 16'h03D4, 16'h03F4, 16'h0414, 16'h0434, 16'h0454, 16'h0474,
    16'h0474, 16'h0494, 16'h04B4, 16'h04D4, 16'h04F4, 16'h0514, 16'h0534, 16'h0534,
    16'h0554, 16'h0554, 16'h0574, 16'h0574, 16'h0573, 16'h0573, 16'h0573, 16'h0572,
    16'h0572, 16'h0572, 16'h0571, 16'h0591, 16'h0591, 16'h0590, 16'h0590, 16'h058F,
    16'h058F, 16'h058F, 16'h058E, 16'h05AE, 16'h05AE, 16'h05AD, 16'h05AD, 16'h05AD,
    16'h05AC, 16'h05AC, 16'h05AB, 16'h05CB, 16'h05CB, 16'h05CA, 16'h05CA, 16'h05CA,
    16'h05C9, 16'h05C9, 16'h05C8, 16'h05E8, 16'h05E8, 16'h05E7, 16'h05E7, 16'h05E6,
    16'h05E6, 16'h05E6, 16'h05E5, 16'h05E5, 16'h0604, 16'h0604, 16'h0604, 16'h0603,
    16'h0603, 16'h0602, 16'h0602, 16'h0601, 16'h0621, 16'h0621, 16'h0620, 16'h0620,
    16'h0620, 16'h0620, 16'h0E20, 16'h0E20, 16'h0E40, 16'h1640, 16'h1640, 16'h1E40,
    16'h1E40, 16'h2640, 16'h2640, 16'h2E40, 16'h2E60, 16'h3660, 16'h3660, 16'h3E60,
    16'h3E60, 16'h3E60, 16'h4660, 16'h4660, 16'h4E60, 16'h4E80, 16'h5680, 16'h5680,
    16'h5E80, 16'h5E80, 16'h6680, 16'h6680, 16'h6E80, 16'h6EA0, 16'h76A0, 16'h76A0,
    16'h7EA0, 16'h7EA0, 16'h86A0, 16'h86A0, 16'h8EA0, 16'h8EC0, 16'h96C0, 16'h96C0,
    16'h9EC0, 16'h9EC0, 16'hA6C0, 16'hAEC0, 16'hAEC0, 16'hB6E0, 16'hB6E0, 16'hBEE0,
    16'hBEE0, 16'hC6E0, 16'hC6E0, 16'hCEE0, 16'hCEE0, 16'hD6E0, 16'hD700, 16'hDF00,
    16'hDEE0, 16'hDEC0, 16'hDEA0, 16'hDE80, 16'hDE80, 16'hE660, 16'hE640, 16'hE620,
    16'hE600, 16'hE5E0, 16'hE5C0, 16'hE5A0, 16'hE580, 16'hE560, 16'hE540, 16'hE520,
    16'hE500, 16'hE4E0, 16'hE4C0, 16'hE4A0, 16'hE480, 16'hE460, 16'hEC40, 16'hEC20,
    16'hEC00, 16'hEBE0, 16'hEBC0, 16'hEBA0, 16'hEB80, 16'hEB60, 16'hEB40, 16'hEB20,
    16'hEB00, 16'hEAE0, 16'hEAC0, 16'hEAA0, 16'hEA80, 16'hEA60, 16'hEA40, 16'hF220,
    16'hF200, 16'hF1E0, 16'hF1C0, 16'hF1A0, 16'hF180, 16'hF160, 16'hF140, 16'hF100,
    16'hF0E0, 16'hF0C0, 16'hF0A0, 16'hF080, 16'hF060, 16'hF040, 16'hF020, 16'hF800
  };

  // One result beat, field by field
  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic [IDX_W-1:0]           color_index;
    logic [COLOR_W-1:0]         color;
    logic                       error;
  } pixel_t;

  // Shadow of the frame store and limit registers; queues the pixel that
  // each accepted command should produce and checks beats in order.
  class pixel_scoreboard;
    logic signed [SAMPLE_W-1:0] frame [STORE_DEPTH];
    logic signed [TEMP_W-1:0]   lo_deg;
    logic signed [TEMP_W-1:0]   hi_deg;
    pixel_t                     pending_pixels [$];
    int n_load, n_fetch, n_reject, n_checked, n_mismatch;

    function new();
      lo_deg = MIN_TEMP_RST;
      hi_deg = MAX_TEMP_RST;
      foreach (frame[i]) frame[i] = '0;
      n_load = 0; n_fetch = 0; n_reject = 0; n_checked = 0; n_mismatch = 0;
    endfunction

    function void set_limits(logic signed [TEMP_W-1:0] lo, logic signed [TEMP_W-1:0] hi);
      lo_deg = lo;
      hi_deg = hi;
    endfunction

    // Load: store at mirrored column. Fetch: 3x bilinear, floor /9, clamp,
    // whole degrees, scale onto the 256-entry palette.
    function pixel_t upscale_pixel(logic op, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
                                   logic signed [SAMPLE_W-1:0] temp);
      pixel_t px;
      int xs, ys, kx, ky, p00, p01, p10, p11, h_top, h_bot, num, q, t, lo, hi, idx;
      px.value = '0;
      px.color_index = '0;
      px.color = '0;
      px.error = 1'b0;
      lo = lo_deg;
      hi = hi_deg;
      if (op == OP_LOAD) begin
        n_load++;
        if (c >= SENSOR_COLS || r >= SENSOR_ROWS) begin
          px.error = 1'b1;
          n_reject++;
        end else begin
          frame[r * SENSOR_COLS + (SENSOR_COLS - 1 - c)] = temp;
        end
      end else begin
        n_fetch++;
        if (c >= FETCH_COLS || r >= FETCH_ROWS) begin
          px.error = 1'b1;
          n_reject++;
        end else begin
          xs = c / 3;
          kx = c % 3;
          ys = r / 3;
          ky = r % 3;
          p00 = frame[ys * SENSOR_COLS + xs];
          p01 = frame[ys * SENSOR_COLS + xs + 1];
          h_top = (2 - kx) * p00 + (kx + 1) * p01;
          h_bot = 0;
          // on a sample row the lower pair has zero weight and may not exist
          if (ky != 0) begin
            p10 = frame[(ys + 1) * SENSOR_COLS + xs];
            p11 = frame[(ys + 1) * SENSOR_COLS + xs + 1];
            h_bot = (2 - kx) * p10 + (kx + 1) * p11;
          end
          num = (3 - ky) * h_top + ky * h_bot;
          q = num / 9;
          if (num % 9 != 0 && num < 0) q = q - 1;
          // clamp order holds even with crossed limits
          if (q >= hi * 64) t = hi;
          else if (q <= lo * 64) t = lo;
          else t = q / 64;
          if (hi == lo) idx = 0;
          else idx = (t - lo) * 255 / (hi - lo);
          px.value = q[SAMPLE_W-1:0];
          px.color_index = idx[IDX_W-1:0];
          px.color = RGB565_LUT[idx[IDX_W-1:0]];
        end
      end
      return px;
    endfunction

    function void note_command(logic op, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
                               logic signed [SAMPLE_W-1:0] temp);
      pending_pixels.push_back(upscale_pixel(op, c, r, temp));
    endfunction

    task report_mismatch(string what, int got, int want);
      n_mismatch++;
      if (n_mismatch <= 40)
        $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      n_checked++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected beat, value", got.value, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (got.value !== want.value) report_mismatch("value", got.value, want.value);
        if (got.color_index !== want.color_index)
          report_mismatch("color_index", got.color_index, want.color_index);
        if (got.color !== want.color) report_mismatch("color", got.color, want.color);
        if (got.error !== want.error) report_mismatch("error", got.error, want.error);
      end
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         start         = 1'b0;
  logic                         busy;
  logic                         opcode_i      = OP_LOAD;
  logic [COORD_W-1:0]           col_i         = '0;
  logic [COORD_W-1:0]           row_i         = '0;
  logic signed [SAMPLE_W-1:0]   temperature_i = '0;
  logic                         cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_idx_i     = CFG_MIN_TEMP;
  logic [TEMP_W-1:0]            cfg_data_i    = '0;
  logic                         done_o;
  logic signed [SAMPLE_W-1:0]   value_o;
  logic [IDX_W-1:0]             color_index_o;
  logic [COLOR_W-1:0]           color_o;
  logic                         error_o;

  pixel_scoreboard sb = new();
  pixel_t          seen_pixel;
  int unsigned     stall_cycles = 0;

  // Stimulus-side bookkeeping: which stored entries hold a sample, so that
  // no fetch ever touches an entry that was never loaded.
  bit loaded [STORE_DEPTH];
  int burst_left = 0;
  int items_sent = 0;
  int n_settings = 0;
  int cur_lo = MIN_TEMP_RST;
  int cur_hi = MAX_TEMP_RST;

  thermal_upscale_colorize_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .col_i         (col_i),
    .row_i         (row_i),
    .temperature_i (temperature_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .value_o       (value_o),
    .color_index_o (color_index_o),
    .color_o       (color_o),
    .error_o       (error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Monitor: values read here are the ones before the edge. A result beat
  // and a new command can land on the same edge; the result is checked
  // first, the new expectation goes to the back of the queue.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o !== 1'b0) begin
        seen_pixel.value = value_o;
        seen_pixel.color_index = color_index_o;
        seen_pixel.color = color_o;
        seen_pixel.error = error_o;
        sb.check_pixel(seen_pixel);
      end
      if (start && busy === 1'b0) sb.note_command(opcode_i, col_i, row_i, temperature_i);
      stall_cycles <= (done_o !== 1'b0 || (start && busy === 1'b0)) ? 0 : stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // Mostly in the sensor's working range, some near the current limits so
  // the clamp edges are hit, some anywhere in 16 bits.
  function automatic logic [SAMPLE_W-1:0] sample_temp();
    int base;
    case ($urandom_range(0, 9))
      0, 1: return SAMPLE_W'($urandom);
      2, 3: begin
        base = ($urandom_range(0, 1) ? cur_hi : cur_lo) * 64;
        return SAMPLE_W'(base + int'($urandom_range(0, 256)) - 128);
      end
      default: return SAMPLE_W'(int'($urandom_range(0, 21760)) - 2560);
    endcase
  endfunction

  // One command beat. The sender runs in bursts; between bursts it usually
  // drops start for a random gap. Returns at the accept edge.
  task automatic issue(logic op, int c, int r, logic [SAMPLE_W-1:0] temp);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    if (op == OP_LOAD && c < SENSOR_COLS && r < SENSOR_ROWS)
      loaded[r * SENSOR_COLS + (SENSOR_COLS - 1 - c)] = 1'b1;
    start         <= 1'b1;
    opcode_i      <= op;
    col_i         <= COORD_W'(c);
    row_i         <= COORD_W'(r);
    temperature_i <= temp;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
  endtask

  // Fetch an upscaled pixel, first loading any neighbor it reads that has
  // not been loaded yet (sensor column is mirrored on load).
  task automatic fetch_pixel(int c, int r);
    int xs, ys, rows_read, pos;
    xs = c / 3;
    ys = r / 3;
    rows_read = (r % 3 != 0) ? 2 : 1;
    for (int dy = 0; dy < rows_read; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        pos = (ys + dy) * SENSOR_COLS + xs + dx;
        if (!loaded[pos]) issue(OP_LOAD, SENSOR_COLS - 1 - (xs + dx), ys + dy, sample_temp());
      end
    end
    issue(OP_FETCH, c, r, SAMPLE_W'($urandom));
  endtask

  // Hold off new commands until every expected beat has come back. The
  // first edge lets the monitor log a command taken on the current edge.
  task automatic drain_results();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Both limits, back to back; only called with the block idle.
  task automatic write_limits(int lo, int hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MIN_TEMP;
    cfg_data_i <= TEMP_W'(lo);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_TEMP;
    cfg_data_i <= TEMP_W'(hi);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_limits(TEMP_W'(lo), TEMP_W'(hi));
    cur_lo = lo;
    cur_hi = hi;
    n_settings++;
  endtask

  // Random mix: about half fetches over the whole valid upscaled grid, a
  // good share of plain loads, and some out-of-range noise.
  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      if ($urandom_range(0, 1))
        issue(OP_LOAD, $urandom_range(0, 127), $urandom_range(0, 127), SAMPLE_W'($urandom));
      else if ($urandom_range(0, 1))
        issue(OP_FETCH, $urandom_range(FETCH_COLS, 127), $urandom_range(0, 127),
              SAMPLE_W'($urandom));
      else
        issue(OP_FETCH, $urandom_range(0, 127), $urandom_range(FETCH_ROWS, 127),
              SAMPLE_W'($urandom));
    end else if (pick < 50) begin
      issue(OP_LOAD, $urandom_range(0, SENSOR_COLS - 1), $urandom_range(0, SENSOR_ROWS - 1),
            sample_temp());
    end else begin
      fetch_pixel($urandom_range(0, FETCH_COLS - 1), $urandom_range(0, FETCH_ROWS - 1));
    end
  endtask

  initial begin : stimulus
    int lo_list [NUM_PHASES];
    int hi_list [NUM_PHASES];
    int phase_end;
    // reset, wide, full 10-bit span, crossed, equal, one degree wide,
    // both at the bottom, then one random setting
    lo_list = '{24, -40, -512, 511, 100, 0, -512, 0};
    hi_list = '{35, 300, 511, -512, 100, 1, -512, 0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: top-left 2x2 at the 16-bit extremes, reset limits
    issue(OP_LOAD, 31, 0, 16'h7FFF);
    issue(OP_LOAD, 30, 0, 16'h8000);
    issue(OP_LOAD, 31, 1, 16'h0000);
    issue(OP_LOAD, 30, 1, 16'hFFFF);
    issue(OP_FETCH, 0, 0, 16'h0000);
    issue(OP_FETCH, 1, 1, 16'hFFFF);
    issue(OP_FETCH, 2, 2, 16'h5555);
    issue(OP_FETCH, 1, 0, 16'hAAAA);  // on a sample row: lower pair unused
    // bottom-right corner, working-range extremes and the two limits
    issue(OP_LOAD, 0, 23, 16'(19200));
    issue(OP_LOAD, 1, 23, 16'(-2560));
    issue(OP_LOAD, 0, 22, 16'(1536));
    issue(OP_LOAD, 1, 22, 16'(2240));
    issue(OP_FETCH, 92, 69, 16'h0000);  // last valid row, reads row 23 only
    issue(OP_FETCH, 92, 68, 16'h0000);
    issue(OP_FETCH, 91, 67, 16'h0000);
    // out of range: last upscaled column, first bad row, all-ones coords
    issue(OP_FETCH, 93, 0, 16'h0000);
    issue(OP_FETCH, 0, 70, 16'h0000);
    issue(OP_FETCH, 127, 127, 16'hFFFF);
    issue(OP_LOAD, 32, 0, 16'h1234);
    issue(OP_LOAD, 0, 24, 16'h1234);
    issue(OP_LOAD, 127, 127, 16'hFFFF);
    // equal limits, then crossed limits
    drain_results();
    write_limits(30, 30);
    issue(OP_FETCH, 1, 1, 16'h0000);
    issue(OP_FETCH, 92, 68, 16'h0000);
    drain_results();
    write_limits(35, 24);
    issue(OP_FETCH, 2, 2, 16'h0000);
    issue(OP_FETCH, 92, 69, 16'h0000);

    // Random phases, one limit setting each, written while idle
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (p == NUM_PHASES - 1) begin
        lo_list[p] = $urandom_range(0, 80) - 40;
        hi_list[p] = lo_list[p] + $urandom_range(1, 260);
      end
      write_limits(lo_list[p], hi_list[p]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        random_item();
        // now and then let the pipe run dry mid-phase
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d loads and %0d fetches (%0d out of range) over %0d limit settings.",
             sb.n_load, sb.n_fetch, sb.n_reject, n_settings);
    $display("Checked %0d result beats, %0d field mismatches.", sb.n_checked, sb.n_mismatch);
    if (sb.n_mismatch == 0 && sb.pending_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
